/* hw/rtl/fdds_pkg.sv */
// Shared types, constants and lookup functions for the four-digit display scanner.
// No dependencies; every other RTL file imports this package.
package fdds_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int DIGIT_W    = 4;
  localparam int SCAN_W     = 2;
  localparam int SEG_W      = 7;
  localparam int CFG_W      = 4;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  localparam logic [DIGIT_W-1:0] HYPHEN_CODE    = 4'd10;
  localparam logic [5:0]         DATE_FIRST_SEC = 6'd50;
  localparam logic [5:0]         DATE_LAST_SEC  = 6'd54;
  localparam logic [CFG_W-1:0]   LED_OFF_RESET  = 4'd2;
  localparam logic [SCAN_W-1:0]  SCAN_RESET     = 2'd3;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic        blink_on;
  } item_t;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] codes_t;
  typedef logic [NUM_DIGITS-1:0]              dots_t;

  // Held drive of the scanned digit
  typedef struct packed {
    logic [NUM_DIGITS-1:0] grid;
    logic [SEG_W-1:0]      segments;
    logic                  dot_level;
  } scan_drive_t;

  // Segment pattern, bit 0 = A; anything past 9 shows a hyphen
  function automatic logic [SEG_W-1:0] seg_lut(input logic [DIGIT_W-1:0] code);
    logic [SEG_W-1:0] pat;
    case (code)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h40;
    endcase
    return pat;
  endfunction

  // Split a value below 64 into tens and ones digit codes: {tens, ones}.
  // q = (v * 205) >> 11 is exact for v < 1029.
  function automatic logic [2*DIGIT_W-1:0] split_tens(input logic [5:0] v);
    logic [13:0] prod;
    logic [2:0]  q;
    logic [5:0]  r;
    prod = 14'(v) * 14'd205;
    q    = prod[13:11];
    r    = v - 6'(q) * 6'd10;
    return {1'b0, q, r[DIGIT_W-1:0]};
  endfunction

endpackage

/* hw/rtl/fdds_digits.sv */
// Digit code and dot store: load from time fields, clear to hyphens.
// Depends on fdds_pkg.
module fdds_digits (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  fdds_pkg::item_t item,
  output fdds_pkg::codes_t codes,
  output fdds_pkg::dots_t  dots
);
  import fdds_pkg::*;

  codes_t codes_next;
  dots_t  dots_next;
  logic [2*DIGIT_W-1:0] hi_pair;
  logic [2*DIGIT_W-1:0] lo_pair;
  logic is_date;

  assign is_date = item.second inside {[DATE_FIRST_SEC:DATE_LAST_SEC]};

  always_comb begin
    hi_pair = is_date ? split_tens(6'(item.day_of_month)) : split_tens(6'(item.hour));
    lo_pair = is_date ? split_tens(6'(item.month)) : split_tens(item.minute);
  end

  always_comb begin
    codes_next = codes;
    dots_next  = dots;
    case (item.mode)
      MODE_LOAD: begin
        codes_next[0] = hi_pair[2*DIGIT_W-1:DIGIT_W];
        codes_next[1] = hi_pair[DIGIT_W-1:0];
        codes_next[2] = lo_pair[2*DIGIT_W-1:DIGIT_W];
        codes_next[3] = lo_pair[DIGIT_W-1:0];
        // date: all dots blink; time: only the hour/minute separator
        dots_next = is_date ? {NUM_DIGITS{item.blink_on}}
                            : {2'b00, item.blink_on, 1'b0};
      end
      MODE_CLEAR: begin
        codes_next = {NUM_DIGITS{HYPHEN_CODE}};
        dots_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      codes <= {NUM_DIGITS{HYPHEN_CODE}};
      dots  <= '0;
    end else if (fire) begin
      codes <= codes_next;
      dots  <= dots_next;
    end
  end

endmodule

/* hw/rtl/fdds_scan.sv */
// Digit scanner: half-rate divider, scan index and held grid/segment/dot drive.
// Depends on fdds_pkg.
module fdds_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tick,
  input  fdds_pkg::codes_t      codes,
  input  fdds_pkg::dots_t       dots,
  output fdds_pkg::scan_drive_t drive_next
);
  import fdds_pkg::*;

  logic              half_rate_flag;
  logic [SCAN_W-1:0] scan_index;
  logic [SCAN_W-1:0] scan_index_next;
  scan_drive_t       drive;
  logic              advance;

  assign advance         = tick && !half_rate_flag;
  assign scan_index_next = scan_index + SCAN_W'(1);

  always_comb begin
    drive_next = drive;
    if (advance) begin
      drive_next.segments  = seg_lut(codes[scan_index_next]);
      drive_next.dot_level = dots[scan_index_next];
      drive_next.grid      = NUM_DIGITS'(1) << scan_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_rate_flag <= 1'b0;
      scan_index     <= SCAN_RESET;
      drive          <= '0;
    end else if (tick) begin
      half_rate_flag <= !half_rate_flag;
      if (advance) begin
        scan_index <= scan_index_next;
      end
      drive <= drive_next;
    end
  end

endmodule

/* hw/rtl/fdds_pwm.sv */
// Backlight PWM: step counter, off-step register and LED level.
// Depends on fdds_pkg.
module fdds_pwm #(
  parameter int PWM_STEPS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       tick,
  input  logic                       cfg_wen,
  input  logic [fdds_pkg::CFG_W-1:0] cfg_wdata,
  output logic                       led_next
);
  import fdds_pkg::*;

  localparam int STEP_W = $clog2(PWM_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PWM_STEPS - 1);

  logic [CFG_W-1:0]  led_off_step;
  logic [STEP_W-1:0] pwm_step;
  logic              led_out;

  // off match wins over the step-zero turn-on
  always_comb begin
    led_next = led_out;
    if (tick) begin
      if (CFG_W'(pwm_step) == led_off_step) begin
        led_next = 1'b0;
      end else if (pwm_step == '0) begin
        led_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_off_step <= LED_OFF_RESET;
    end else if (cfg_wen) begin
      led_off_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_step <= '0;
      led_out  <= 1'b0;
    end else if (tick) begin
      pwm_step <= (pwm_step == STEP_LAST) ? '0 : pwm_step + STEP_W'(1);
      led_out  <= led_next;
    end
  end

endmodule

/* hw/rtl/four_digit_display_scanner_top.sv */
// Four-digit multiplexed seven-segment scanner with PWM backlight, top level.
// Each input beat passes the input register, then the result register, and gives exactly
// one result beat. Throughput: one beat per cycle while m_axis_tready does not stall.
// rst (synchronous, active high) sets hyphens on all digits, dots off, scan index 3,
// drive outputs low and the LED off step to 2. Depends on fdds_pkg and fdds_* modules.
module four_digit_display_scanner_top #(
  parameter int PWM_STEPS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration: LED off step
  input  logic                            cfg_wen,
  input  logic [fdds_pkg::CFG_W-1:0]      cfg_wdata,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [4:0] hour, [10:5] minute, [16:11] second, [21:17] day_of_month,
  // [25:22] month, [26] blink_on, [31:27] zero
  input  logic [fdds_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [fdds_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] grid, [10:4] segments, [11] dot_level, [12] led_level, [15:13] zero
  output logic [fdds_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import fdds_pkg::*;

  // ---- input register stage
  logic  a_valid;
  item_t a_item;
  item_t in_item;
  logic  adv;      // item moves from input register into the result register

  // ---- result register stage
  logic                  b_valid;
  logic [OUT_DATA_W-1:0] b_data;

  // ---- state units
  codes_t      codes;
  dots_t       dots;
  scan_drive_t drive_next;
  logic        led_next;
  logic        tick;

  // unpack the beat into the item fields
  always_comb begin
    in_item.mode         = mode_t'(s_axis_tuser);
    in_item.hour         = s_axis_tdata[4:0];
    in_item.minute       = s_axis_tdata[10:5];
    in_item.second       = s_axis_tdata[16:11];
    in_item.day_of_month = s_axis_tdata[21:17];
    in_item.month        = s_axis_tdata[25:22];
    in_item.blink_on     = s_axis_tdata[26];
  end

  // Item-driven state is updated exactly when an item leaves the input register, so the
  // result register always holds the drive levels after that item.
  assign adv           = a_valid && (!b_valid || m_axis_tready);
  assign s_axis_tready = !a_valid || adv;
  assign tick          = adv && (a_item.mode == MODE_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_item <= in_item;
    end
  end

  fdds_digits u_digits (
    .clk   (clk),
    .rst   (rst),
    .fire  (adv),
    .item  (a_item),
    .codes (codes),
    .dots  (dots)
  );

  // scan reads the digit store as it stands; ticks never change it
  fdds_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .codes      (codes),
    .dots       (dots),
    .drive_next (drive_next)
  );

  fdds_pwm #(
    .PWM_STEPS (PWM_STEPS)
  ) u_pwm (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .led_next  (led_next)
  );

  // result register; refilled in the same cycle it is drained
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= 1'b1;
    end else if (m_axis_tready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_data <= {3'b000, led_next, drive_next.dot_level, drive_next.segments,
                 drive_next.grid};
    end
  end

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = b_data;

  // ---- checks
  // at most one digit is ever enabled
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[3:0]))
    else $error("grid drive not one-hot");

  // with no digit scanned yet, segments and dot stay dark
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[3:0] == 4'd0)) |-> (m_axis_tdata[11:4] == 8'd0))
    else $error("segments lit with no digit enabled");

  // an item held in the input register is not dropped while the result side stalls
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && !adv) |=> a_valid)
    else $error("input register lost an item");

  // an item leaving the input register always lands in the result register
  assert property (@(posedge clk) disable iff (rst)
    adv |=> b_valid)
    else $error("result register not loaded");

endmodule
